@@ src/qct_pkg.sv @@
// ----------------------------------------------------------------------------
// qct_pkg
// Shared widths, constants and types of the quorum commit tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package qct_pkg;

   localparam int NUM_REPLICAS = 8;
   localparam int ID_W         = 3;
   localparam int SEQ_W        = 32;
   localparam int QUORUM_W     = 4;
   localparam int IDX_W        = (NUM_REPLICAS > 1) ? $clog2(NUM_REPLICAS) : 1;
   localparam int CNT_W        = $clog2(NUM_REPLICAS + 1);
   localparam int CMP_W        = (CNT_W > QUORUM_W) ? CNT_W : QUORUM_W;

   // The queue depth must stay a power of two so that the pointers wrap.
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic signed [SEQ_W-1:0]    SEQ_NONE     = '1;
   localparam logic        [QUORUM_W-1:0] QUORUM_RESET = QUORUM_W'(5);

   typedef struct packed {
      logic                    in_range;
      logic [ID_W-1:0]         replica_id;
      logic signed [SEQ_W-1:0] acked_seq;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ src/quorum_commit_tracker.sv @@
// ----------------------------------------------------------------------------
// quorum_commit_tracker
// Tracks replica acknowledgements and advances the quorum commit sequence.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    replica_id, acked_seq
//   rsp_      out        rsp_valid/rsp_ready    committed_seq, commit_advanced
//   csr_      in         csr_wr_en              quorum_size (csr_wr_data)
//
// An acknowledgement that is out of range or does not raise above the committed
// sequence is answered directly by the back end; one that does goes through the
// scan, which tests one stored sequence per cycle against all of them.
// The item is registered in the front stage and then in the two-entry queue.
// Reset restores control, sequences and quorum; there is no clearing pass.
// A stalled result stops the back end but not a scan; the front fills the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module quorum_commit_tracker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [qct_pkg::ID_W-1:0]            req_replica_id,
   input  wire logic signed [qct_pkg::SEQ_W-1:0]    req_acked_seq,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [qct_pkg::SEQ_W-1:0]         rsp_committed_seq,
   output logic                                     rsp_commit_advanced,
   input  wire logic                                csr_wr_en,
   input  wire logic [qct_pkg::QUORUM_W-1:0]        csr_wr_data
);

   logic             front_valid;
   logic             front_ready;
   qct_pkg::cmd_type front_cmd;
   logic             back_valid;
   logic             back_ready;
   qct_pkg::cmd_type back_cmd;

   qct_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_replica_id (req_replica_id),
      .req_acked_seq  (req_acked_seq),
      .cmd_valid      (front_valid),
      .cmd_ready      (front_ready),
      .cmd            (front_cmd)
   );

   qct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   qct_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (back_valid),
      .q_ready             (back_ready),
      .q_cmd               (back_cmd),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_committed_seq   (rsp_committed_seq),
      .rsp_commit_advanced (rsp_commit_advanced)
   );

endmodule

`default_nettype wire

@@ src/qct_front.sv @@
// ----------------------------------------------------------------------------
// qct_front
// Accepts acknowledgements, checks the replica id and holds the item for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qct_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [qct_pkg::ID_W-1:0]        req_replica_id,
   input  wire logic signed [qct_pkg::SEQ_W-1:0] req_acked_seq,
   output logic                                 cmd_valid,
   input  wire logic                            cmd_ready,
   output qct_pkg::cmd_type                     cmd
);

   logic             stage_valid_ff;
   logic             stage_valid_in;
   qct_pkg::cmd_type stage_ff;
   qct_pkg::cmd_type stage_in;
   logic             take;

   assign req_ready = !stage_valid_ff || cmd_ready;
   assign take      = req_valid && req_ready;
   assign cmd_valid = stage_valid_ff;
   assign cmd       = stage_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (take) begin
         stage_valid_in = 1'b1;
      end else if (cmd_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      stage_in = stage_ff;
      if (take) begin
         stage_in.in_range   = 32'(req_replica_id) < qct_pkg::NUM_REPLICAS;
         stage_in.replica_id = req_replica_id;
         stage_in.acked_seq  = req_acked_seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

`default_nettype wire

@@ src/qct_queue.sv @@
// ----------------------------------------------------------------------------
// qct_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module qct_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire qct_pkg::cmd_type push_cmd,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output qct_pkg::cmd_type      pop_cmd
);

   qct_pkg::cmd_type                  entry_ff [qct_pkg::QUEUE_DEPTH];
   logic [qct_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [qct_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [qct_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [qct_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [qct_pkg::QPTR_W:0]          count_ff;
   logic [qct_pkg::QPTR_W:0]          count_in;
   logic                              push;
   logic                              pop;

   assign push_ready = count_ff != (qct_pkg::QPTR_W+1)'(qct_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ src/qct_back.sv @@
// ----------------------------------------------------------------------------
// qct_back
// Stores acknowledged sequences, scans for the quorum value and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module qct_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                q_valid,
   output logic                                     q_ready,
   input  wire qct_pkg::cmd_type                    q_cmd,
   input  wire logic                                csr_wr_en,
   input  wire logic [qct_pkg::QUORUM_W-1:0]        csr_wr_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [qct_pkg::SEQ_W-1:0]         rsp_committed_seq,
   output logic                                     rsp_commit_advanced
);

   qct_pkg::state_type               state_ff;
   qct_pkg::state_type               state_in;
   logic signed [qct_pkg::SEQ_W-1:0] replica_seq_ff [qct_pkg::NUM_REPLICAS];
   logic signed [qct_pkg::SEQ_W-1:0] replica_seq_in [qct_pkg::NUM_REPLICAS];
   logic signed [qct_pkg::SEQ_W-1:0] commit_ff;
   logic signed [qct_pkg::SEQ_W-1:0] commit_in;
   logic signed [qct_pkg::SEQ_W-1:0] best_ff;
   logic signed [qct_pkg::SEQ_W-1:0] best_in;
   logic [qct_pkg::IDX_W-1:0]        idx_ff;
   logic [qct_pkg::IDX_W-1:0]        idx_in;
   logic [qct_pkg::QUORUM_W-1:0]     quorum_ff;
   logic [qct_pkg::QUORUM_W-1:0]     quorum_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic signed [qct_pkg::SEQ_W-1:0] rsp_seq_ff;
   logic signed [qct_pkg::SEQ_W-1:0] rsp_seq_in;
   logic                             rsp_adv_ff;
   logic                             rsp_adv_in;

   logic                             out_free;
   logic                             needs_scan;
   logic                             scan_last;
   logic                             pop;
   logic                             store_wr;
   logic                             direct;
   logic                             scan_step;
   logic                             finish;
   logic                             advance;
   logic signed [qct_pkg::SEQ_W-1:0] cand;
   logic [qct_pkg::CNT_W-1:0]        count;
   logic                             qualifies;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign needs_scan = q_cmd.in_range && (q_cmd.acked_seq > commit_ff);
   assign scan_last  = idx_ff == qct_pkg::IDX_W'(qct_pkg::NUM_REPLICAS - 1);
   assign cand       = replica_seq_ff[idx_ff];
   assign advance    = best_ff > commit_ff;

   always_comb begin
      count = '0;
      for (int r = 0; r < qct_pkg::NUM_REPLICAS; r++) begin
         count = count + qct_pkg::CNT_W'(replica_seq_ff[r] >= cand);
      end
   end

   assign qualifies = (cand > qct_pkg::SEQ_NONE) && (cand > best_ff) &&
                      (qct_pkg::CMP_W'(count) >= qct_pkg::CMP_W'(quorum_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qct_pkg::ST_IDLE: begin
            if (q_valid && out_free && needs_scan) begin
               state_in = qct_pkg::ST_SCAN;
            end
         end
         qct_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = qct_pkg::ST_DONE;
            end
         end
         qct_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = qct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qct_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      scan_step = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         qct_pkg::ST_IDLE: begin
            pop = q_valid && out_free;
         end
         qct_pkg::ST_SCAN: begin
            scan_step = 1'b1;
         end
         qct_pkg::ST_DONE: begin
            finish = out_free;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign q_ready  = pop;
   assign store_wr = pop && q_cmd.in_range;
   assign direct   = pop && !needs_scan;

   always_comb begin
      for (int r = 0; r < qct_pkg::NUM_REPLICAS; r++) begin
         replica_seq_in[r] = replica_seq_ff[r];
         if (store_wr && (32'(q_cmd.replica_id) == r)) begin
            replica_seq_in[r] = q_cmd.acked_seq;
         end
      end
   end

   always_comb begin
      best_in = best_ff;
      idx_in  = idx_ff;
      if (pop) begin
         best_in = qct_pkg::SEQ_NONE;
         idx_in  = '0;
      end else if (scan_step) begin
         if (qualifies) begin
            best_in = cand;
         end
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      commit_in    = commit_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_adv_in   = rsp_adv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (direct) begin
         rsp_valid_in = 1'b1;
         rsp_seq_in   = commit_ff;
         rsp_adv_in   = 1'b0;
      end else if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_adv_in   = advance;
         if (advance) begin
            commit_in  = best_ff;
            rsp_seq_in = best_ff;
         end else begin
            rsp_seq_in = commit_ff;
         end
      end
   end

   assign quorum_in = csr_wr_en ? csr_wr_data : quorum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qct_pkg::ST_IDLE;
         commit_ff    <= qct_pkg::SEQ_NONE;
         quorum_ff    <= qct_pkg::QUORUM_RESET;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < qct_pkg::NUM_REPLICAS; r++) begin
            replica_seq_ff[r] <= qct_pkg::SEQ_NONE;
         end
      end else begin
         state_ff     <= state_in;
         commit_ff    <= commit_in;
         quorum_ff    <= quorum_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int r = 0; r < qct_pkg::NUM_REPLICAS; r++) begin
            replica_seq_ff[r] <= replica_seq_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff    <= best_in;
      idx_ff     <= idx_in;
      rsp_seq_ff <= rsp_seq_in;
      rsp_adv_ff <= rsp_adv_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_committed_seq   = rsp_seq_ff;
   assign rsp_commit_advanced = rsp_adv_ff;

   // The committed sequence never moves backward.
   a_commit_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> commit_ff >= $past(commit_ff))
      else $error("committed sequence decreased");

   // A waiting result always reports the current committed sequence.
   a_rsp_matches_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_seq_ff == commit_ff)
      else $error("result does not match committed sequence");

   // An advance is never reported to the unacknowledged value.
   a_adv_above_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_adv_ff |-> rsp_seq_ff > qct_pkg::SEQ_NONE)
      else $error("advance reported without a valid sequence");

   // Every scan starts at the first replica with no candidate found.
   a_scan_starts_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff != qct_pkg::ST_SCAN ##1 state_ff == qct_pkg::ST_SCAN
      |-> idx_ff == '0 && best_ff == qct_pkg::SEQ_NONE)
      else $error("scan started from a stale index or candidate");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the quorum commit tracker.
// A driver feeds acknowledgements from a queue, and a monitor compares every
// result with a commit index predicted in the testbench. Both sides stall at
// random. The quorum size is changed between phases, including zero and
// values above the replica count.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 10;

   typedef struct {
      logic [qct_pkg::ID_W-1:0]         replica_id;
      logic signed [qct_pkg::SEQ_W-1:0] acked_seq;
   } ack_item_type;

   typedef struct {
      logic signed [qct_pkg::SEQ_W-1:0] committed_seq;
      logic                             advanced;
   } commit_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [qct_pkg::ID_W-1:0]         req_replica_id = '0;
   logic signed [qct_pkg::SEQ_W-1:0] req_acked_seq = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic signed [qct_pkg::SEQ_W-1:0] rsp_committed_seq;
   logic                             rsp_commit_advanced;
   logic                             csr_wr_en = 1'b0;
   logic [qct_pkg::QUORUM_W-1:0]     csr_wr_data = '0;

   ack_item_type                     pending_acks[$];
   commit_result_type                commit_expect[$];

   logic signed [qct_pkg::SEQ_W-1:0] seq_mirror[qct_pkg::NUM_REPLICAS];
   logic signed [qct_pkg::SEQ_W-1:0] commit_mirror = qct_pkg::SEQ_NONE;
   logic [qct_pkg::QUORUM_W-1:0]     quorum_mirror = qct_pkg::QUORUM_RESET;

   int                               items_queued = 0;
   int                               results_seen = 0;
   int                               advances_seen = 0;
   int                               fail_count = 0;
   int                               quorum_writes = 0;
   int                               cycle_count = 0;
   int                               req_wait = 0;
   int                               rsp_wait = 0;
   logic                             req_calm = 1'b0;
   logic                             rsp_calm = 1'b1;
   longint                           ack_base = 0;

   quorum_commit_tracker i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_replica_id      (req_replica_id),
      .req_acked_seq       (req_acked_seq),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_committed_seq   (rsp_committed_seq),
      .rsp_commit_advanced (rsp_commit_advanced),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < qct_pkg::NUM_REPLICAS; i++) begin
         seq_mirror[i] = qct_pkg::SEQ_NONE;
      end
   end

   // Stores the acknowledgement and advances the commit index when some
   // value is reached or passed by at least a quorum of replicas.
   function automatic void record_ack(input logic [qct_pkg::ID_W-1:0] id,
                                      input logic signed [qct_pkg::SEQ_W-1:0] seq);
      commit_result_type                res;
      logic signed [qct_pkg::SEQ_W-1:0] best;
      logic signed [qct_pkg::SEQ_W-1:0] cand;
      int                               count;
      res.advanced = 1'b0;
      seq_mirror[id] = seq;
      if (seq > commit_mirror) begin
         best = qct_pkg::SEQ_NONE;
         for (int i = 0; i < qct_pkg::NUM_REPLICAS; i++) begin
            cand = seq_mirror[i];
            if (cand > best) begin
               count = 0;
               for (int j = 0; j < qct_pkg::NUM_REPLICAS; j++) begin
                  if (seq_mirror[j] >= cand) begin
                     count++;
                  end
               end
               if (count >= int'(quorum_mirror)) begin
                  best = cand;
               end
            end
         end
         if (best > commit_mirror) begin
            commit_mirror = best;
            res.advanced = 1'b1;
         end
      end
      res.committed_seq = commit_mirror;
      commit_expect.push_back(res);
   endfunction

   function automatic int draw_gap(inout logic calm);
      if ($urandom_range(0, 29) == 0) begin
         calm = ~calm;
      end
      return calm ? 0 : int'($urandom_range(0, 13));
   endfunction

   always @(posedge clock) begin : drive_acks
      ack_item_type nxt;
      logic         still_up;
      if (reset) begin
         req_valid <= 1'b0;
         req_wait  <= 0;
      end else begin
         still_up = req_valid;
         if (req_valid && req_ready) begin
            record_ack(req_replica_id, req_acked_seq);
            still_up = 1'b0;
         end
         if (!still_up) begin
            if (req_wait != 0) begin
               req_wait  <= req_wait - 1;
               req_valid <= 1'b0;
            end else if (pending_acks.size() != 0) begin
               nxt = pending_acks.pop_front();
               req_valid      <= 1'b1;
               req_replica_id <= nxt.replica_id;
               req_acked_seq  <= nxt.acked_seq;
               req_wait       <= draw_gap(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_commits
      commit_result_type want;
      int                gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_commit_advanced === 1'b1) begin
               advances_seen++;
            end
            if (commit_expect.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("Unexpected result: committed_seq %0d advanced %0b",
                           rsp_committed_seq, rsp_commit_advanced);
               end
            end else begin
               want = commit_expect.pop_front();
               results_seen++;
               if (rsp_committed_seq !== want.committed_seq ||
                   rsp_commit_advanced !== want.advanced) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display({"Mismatch on item %0d: expected seq %0d adv %0b, ",
                               "got seq %0d adv %0b"},
                              results_seen, want.committed_seq, want.advanced,
                              rsp_committed_seq, rsp_commit_advanced);
                  end
               end
            end
            gap = draw_gap(rsp_calm);
            rsp_wait  <= gap;
            rsp_ready <= (gap == 0);
         end else if (rsp_wait != 0) begin
            rsp_wait  <= rsp_wait - 1;
            rsp_ready <= (rsp_wait == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d of %0d results checked",
                  cycle_count, results_seen, items_queued);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic push_ack(input logic [qct_pkg::ID_W-1:0] id,
                           input logic signed [qct_pkg::SEQ_W-1:0] seq);
      ack_item_type a;
      a.replica_id = id;
      a.acked_seq  = seq;
      pending_acks.push_back(a);
      items_queued++;
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (results_seen != items_queued);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_quorum(input logic [qct_pkg::QUORUM_W-1:0] q);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= q;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      quorum_mirror = q;
      quorum_writes++;
   endtask

   // Most acknowledgements land just ahead of a slowly rising base, as a
   // healthy replica set would send them. The rest are lagging replicas,
   // unacknowledged markers and random negative noise.
   task automatic push_random_acks(input int count);
      logic signed [qct_pkg::SEQ_W-1:0] seq;
      longint                           v;
      int                               pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            v = ack_base + $urandom_range(0, 12);
         end else if (pick < 86) begin
            v = ack_base - $urandom_range(1, 40);
         end else if (pick < 92) begin
            v = -longint'($urandom_range(1, 3));
         end else begin
            v = 0;
         end
         if (v > longint'(32'h7FFF_FFFF)) begin
            v = 32'h7FFF_FFFF;
         end
         seq = (pick < 92) ? qct_pkg::SEQ_W'(v) : {1'b1, 31'($urandom)};
         push_ack(qct_pkg::ID_W'($urandom_range(0, qct_pkg::NUM_REPLICAS - 1)), seq);
         if ($urandom_range(0, 2) == 0) begin
            ack_base += $urandom_range(0, 4);
         end
      end
   endtask

   initial begin
      logic [qct_pkg::QUORUM_W-1:0] phase_quorum[12] = '{3, 1, 8, 0, 5, 9, 2, 7, 15, 4, 6, 3};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      push_ack(0, qct_pkg::SEQ_NONE);
      push_ack(7, 32'sh7FFF_FFFF);
      push_ack(7, 32'sh8000_0000);
      push_ack(1, -32'sd5);
      for (int i = 0; i < 5; i++) begin
         push_ack(qct_pkg::ID_W'(i), 10 * (i + 1));
      end
      push_ack(2, 5);
      push_ack(5, 10);

      write_quorum(0);
      push_ack(6, 100);
      write_quorum(15);
      push_ack(3, 500);
      write_quorum(8);
      for (int i = 0; i < qct_pkg::NUM_REPLICAS; i++) begin
         push_ack(qct_pkg::ID_W'(i), 200 + i);
      end
      write_quorum(1);
      push_ack(4, 300);

      ack_base = 1000;
      foreach (phase_quorum[p]) begin
         write_quorum(phase_quorum[p]);
         push_random_acks(125);
      end

      // Sequence numbers near the top of the signed range.
      write_quorum(2);
      ack_base = 32'h7FFF_FFE0;
      push_random_acks(100);

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Checked %0d acknowledgements under %0d quorum settings.",
               results_seen, quorum_writes + 1);
      $display("The commit index advanced %0d times and ended at %0d.",
               advances_seen, commit_mirror);
      if (fail_count == 0 && commit_expect.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Failures: %0d, results still outstanding: %0d",
                  fail_count, commit_expect.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
